[design/assert_macros.svh]
// Assertion macros used by the checker module.
// A property is sampled on i_clk; all but FVNH_ASSERT_ALWAYS are ignored while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked outside reset.
`define FVNH_ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define FVNH_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define FVNH_ASSERT_ALWAYS(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

[design/fvnh_pkg.sv]
// ----------------------------------------------------------------------------
// fvnh_pkg
// Shared constants and arithmetic helpers of the fractal noise height block.
// ----------------------------------------------------------------------------
`default_nettype none

package fvnh_pkg;

    localparam int STEP_W     = 20;
    localparam int HEIGHT_W   = 24;
    localparam int OUT_W      = 26;
    localparam int FRAC_W     = 16;
    localparam int VAL_W      = 33;
    localparam int OCTAVES_DEF    = 6;
    localparam int COORD_BITS_DEF = 12;

    localparam logic [STEP_W-1:0]   STEP_RST   = 20'd65536;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 24'd256;

    localparam logic [31:0] HASH_ROW  = 32'd57;
    localparam logic [31:0] HASH_MUL  = 32'd15731;
    localparam logic [31:0] HASH_ADD1 = 32'd789221;
    localparam logic [31:0] HASH_ADD2 = 32'd1376312589;

    // Register indices on the configuration port.
    typedef enum logic {
        REG_COORD_STEP = 1'b0,
        REG_MAX_HEIGHT = 1'b1
    } t_reg;

    // Linear blend of two values by a 16-bit fraction, rounded down.
    function automatic logic signed [VAL_W-1:0] blend(
        input logic signed [VAL_W-1:0] a,
        input logic signed [VAL_W-1:0] b,
        input logic [FRAC_W-1:0]       f
    );
        logic signed [63:0] wa;
        logic signed [63:0] wb;
        logic signed [63:0] p;
        wa = 64'(signed'({1'b0, 17'h10000 - {1'b0, f}}));
        wb = 64'(signed'({2'b0, f}));
        p  = (64'(a) * wa + 64'(b) * wb) >>> FRAC_W;
        return p[VAL_W-1:0];
    endfunction

endpackage

`default_nettype wire

[design/fractal_value_noise_height.sv]
// ----------------------------------------------------------------------------
// fractal_value_noise_height
// Terrain height of a grid point from OCTAVES octaves (six by default) of smoothed value noise.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; i_grid_x and
// i_grid_z are sampled at that edge. The height appears on o_height for one
// cycle with o_done high, in request order, and the receiver cannot hold it.
// The lattice pipeline handles one octave per cycle, so a point occupies it
// for all OCTAVES octaves (six by default), and the next point enters as
// soon as the last octave of the one before has been issued.
// A two-entry queue behind the scaling stage absorbs bursts; busy rises only
// once that queue and the scaling stage are full.
// coord_step (address 0) and max_height (address 4) are written through the
// APB port; the user must write them only while no request is in flight, as
// the block does not enforce it. Reset, synchronous and active low, empties
// the pipeline and queue and restores coord_step to 1.0, max_height to 256.
// ----------------------------------------------------------------------------
`default_nettype none

module fractal_value_noise_height #(
    parameter int OCTAVES    = fvnh_pkg::OCTAVES_DEF,
    parameter int COORD_BITS = fvnh_pkg::COORD_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [COORD_BITS-1:0]        i_grid_x,
    input  wire logic [COORD_BITS-1:0]        i_grid_z,
    output logic                              o_done,
    output logic signed [fvnh_pkg::OUT_W-1:0] o_height,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [2:0]                   paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    localparam int BW = COORD_BITS + fvnh_pkg::STEP_W;

    logic [fvnh_pkg::STEP_W-1:0]   r_coord_step;
    logic [fvnh_pkg::HEIGHT_W-1:0] r_max_height;
    fvnh_pkg::t_reg                reg_sel;

    // The byte offset within a word is not decoded.
    assign reg_sel = fvnh_pkg::t_reg'(paddr[2]);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coord_step <= fvnh_pkg::STEP_RST;
            r_max_height <= fvnh_pkg::HEIGHT_RST;
        end else if (psel && penable && pwrite) begin
            case (reg_sel)
                fvnh_pkg::REG_COORD_STEP: r_coord_step <= pwdata[fvnh_pkg::STEP_W-1:0];
                fvnh_pkg::REG_MAX_HEIGHT: r_max_height <= pwdata[fvnh_pkg::HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            fvnh_pkg::REG_COORD_STEP: prdata = 32'(r_coord_step);
            fvnh_pkg::REG_MAX_HEIGHT: prdata = 32'(r_max_height);
            default:                  prdata = '0;
        endcase
    end

    logic          push;
    logic [BW-1:0] f_bx;
    logic [BW-1:0] f_bz;
    logic          q_full;
    logic          q_valid;
    logic          q_pop;
    logic [2*BW-1:0] q_data;

    fvnh_front #(.COORD_BITS(COORD_BITS), .BW(BW)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_grid_x     (i_grid_x),
        .i_grid_z     (i_grid_z),
        .i_coord_step (r_coord_step),
        .i_q_full     (q_full),
        .o_busy       (busy),
        .o_push       (push),
        .o_bx         (f_bx),
        .o_bz         (f_bz)
    );

    fvnh_queue #(.W(2*BW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_bx, f_bz}),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_data  (q_data)
    );

    fvnh_back #(.OCTAVES(OCTAVES), .COORD_BITS(COORD_BITS), .BW(BW)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_bx       (q_data[2*BW-1:BW]),
        .i_q_bz       (q_data[BW-1:0]),
        .o_q_pop      (q_pop),
        .i_max_height (r_max_height),
        .o_done       (o_done),
        .o_height     (o_height)
    );

endmodule

`default_nettype wire

[design/fvnh_queue.sv]
// ----------------------------------------------------------------------------
// fvnh_queue
// Two-entry queue between the scaling front end and the octave back end.
// ----------------------------------------------------------------------------
`default_nettype none

module fvnh_queue #(
    parameter int W = 64
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    input  wire logic         i_pop,
    output logic              o_valid,
    output logic              o_full,
    output logic [W-1:0]      o_data
);

    logic [W-1:0] r_mem [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_data  = r_mem[r_rp];

endmodule

`default_nettype wire

[design/fvnh_front.sv]
// ----------------------------------------------------------------------------
// fvnh_front
// Takes requests and scales the grid point by the coordinate step.
// ----------------------------------------------------------------------------
`default_nettype none

module fvnh_front #(
    parameter int COORD_BITS = fvnh_pkg::COORD_BITS_DEF,
    parameter int BW         = COORD_BITS + fvnh_pkg::STEP_W
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [COORD_BITS-1:0]       i_grid_x,
    input  wire logic [COORD_BITS-1:0]       i_grid_z,
    input  wire logic [fvnh_pkg::STEP_W-1:0] i_coord_step,
    input  wire logic                        i_q_full,
    output logic                             o_busy,
    output logic                             o_push,
    output logic [BW-1:0]                    o_bx,
    output logic [BW-1:0]                    o_bz
);

    logic r_vld;
    logic accept;

    assign o_busy = r_vld & i_q_full;
    assign o_push = r_vld & ~i_q_full;
    assign accept = i_start & ~o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= accept | (r_vld & ~o_push);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            o_bx <= BW'(i_grid_x) * BW'(i_coord_step);
            o_bz <= BW'(i_grid_z) * BW'(i_coord_step);
        end
    end

endmodule

`default_nettype wire

[design/fvnh_back.sv]
// ----------------------------------------------------------------------------
// fvnh_back
// Octave sequencer and lattice pipeline: hash, smooth, blend, sum and scale.
// ----------------------------------------------------------------------------
`default_nettype none

module fvnh_back #(
    parameter int OCTAVES    = fvnh_pkg::OCTAVES_DEF,
    parameter int COORD_BITS = fvnh_pkg::COORD_BITS_DEF,
    parameter int BW         = COORD_BITS + fvnh_pkg::STEP_W
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_q_valid,
    input  wire logic [BW-1:0]                 i_q_bx,
    input  wire logic [BW-1:0]                 i_q_bz,
    output logic                               o_q_pop,
    input  wire logic [fvnh_pkg::HEIGHT_W-1:0] i_max_height,
    output logic                               o_done,
    output logic signed [fvnh_pkg::OUT_W-1:0]  o_height
);

    localparam int OW  = (OCTAVES > 1) ? $clog2(OCTAVES) : 1;
    localparam int PW  = BW + OCTAVES - 1;
    localparam int FW  = fvnh_pkg::FRAC_W;
    localparam int VW  = fvnh_pkg::VAL_W;
    localparam int NT  = 8;
    localparam int AW  = VW + 1;
    localparam int PRW = AW + fvnh_pkg::HEIGHT_W + 1;
    localparam logic signed [fvnh_pkg::OUT_W-1:0] OMAX = {1'b0, {(fvnh_pkg::OUT_W-1){1'b1}}};
    localparam logic signed [fvnh_pkg::OUT_W-1:0] OMIN = {1'b1, {(fvnh_pkg::OUT_W-1){1'b0}}};

    // Octave sequencer
    logic          r_run;
    logic [OW-1:0] r_oct;
    logic [BW-1:0] r_bx;
    logic [BW-1:0] r_bz;
    logic          last_iss;

    assign last_iss = r_run && (r_oct == OW'(OCTAVES - 1));
    assign o_q_pop  = i_q_valid && (!r_run || last_iss);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_oct <= '0;
        end else if (o_q_pop) begin
            r_run <= 1'b1;
            r_oct <= '0;
        end else if (last_iss) begin
            r_run <= 1'b0;
        end else if (r_run) begin
            r_oct <= r_oct + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_bx <= i_q_bx;
            r_bz <= i_q_bz;
        end
    end

    // Tags travelling with each octave through the pipeline
    logic          r_vld  [NT];
    logic          r_last [NT];
    logic [OW-1:0] r_toct [NT];
    logic [FW-1:0] r_fx   [NT];
    logic [FW-1:0] r_fz   [NT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NT; k++) r_vld[k] <= 1'b0;
        end else begin
            r_vld[0] <= r_run;
            for (int k = 1; k < NT; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // Stage 0: scaled coordinate split into lattice index and fraction
    logic [PW-1:0] px;
    logic [PW-1:0] pz;
    logic [31:0]   r_ix;
    logic [31:0]   r_iz;

    assign px = PW'(r_bx) << r_oct;
    assign pz = PW'(r_bz) << r_oct;

    always_ff @(posedge i_clk) begin
        r_ix      <= 32'(px[PW-1:FW]);
        r_iz      <= 32'(pz[PW-1:FW]);
        r_fx[0]   <= px[FW-1:0];
        r_fz[0]   <= pz[FW-1:0];
        r_toct[0] <= r_oct;
        r_last[0] <= last_iss;
        for (int k = 1; k < NT; k++) begin
            r_fx[k]   <= r_fx[k-1];
            r_fz[k]   <= r_fz[k-1];
            r_toct[k] <= r_toct[k-1];
            r_last[k] <= r_last[k-1];
        end
    end

    // Stages 1 to 4: hash of the 4x4 lattice points around the cell
    logic [31:0]          r_n1 [16];
    logic [31:0]          r_n2 [16];
    logic [31:0]          r_sq [16];
    logic [31:0]          r_n3 [16];
    logic [31:0]          r_a  [16];
    logic signed [VW-1:0] r_v  [16];

    always_ff @(posedge i_clk) begin
        for (int b = 0; b < 4; b++) begin
            for (int a = 0; a < 4; a++) begin
                logic [31:0] x;
                logic [31:0] z;
                logic [31:0] n;
                x = r_ix + 32'(a) - 32'd1;
                z = r_iz + 32'(b) - 32'd1;
                n = x + z * fvnh_pkg::HASH_ROW;
                r_n1[b*4+a] <= (n << 13) ^ n;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 16; i++) begin
            logic [31:0] m;
            logic [30:0] t;
            r_n2[i] <= r_n1[i];
            r_sq[i] <= r_n1[i] * r_n1[i];
            r_n3[i] <= r_n2[i];
            r_a[i]  <= r_sq[i] * fvnh_pkg::HASH_MUL + fvnh_pkg::HASH_ADD1;
            m = r_n3[i] * r_a[i] + fvnh_pkg::HASH_ADD2;
            t = m[30:0];
            r_v[i] <= signed'(VW'(33'h040000000)) - signed'({2'b0, t});
        end
    end

    // Stage 5: 3x3 smoothing at the four cell corners
    logic signed [VW-1:0] r_s [4];

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 4; c++) begin
            logic signed [VW+3:0] acc;
            int cx;
            int cz;
            cx  = 1 + (c % 2);
            cz  = 1 + (c / 2);
            acc = (VW+4)'(r_v[(cz-1)*4+cx-1]) + (VW+4)'(r_v[(cz-1)*4+cx+1])
                + (VW+4)'(r_v[(cz+1)*4+cx-1]) + (VW+4)'(r_v[(cz+1)*4+cx+1])
                + (((VW+4)'(r_v[cz*4+cx-1]) + (VW+4)'(r_v[cz*4+cx+1])
                  + (VW+4)'(r_v[(cz-1)*4+cx]) + (VW+4)'(r_v[(cz+1)*4+cx])) <<< 1)
                + ((VW+4)'(r_v[cz*4+cx]) <<< 2);
            r_s[c] <= VW'(acc >>> 4);
        end
    end

    // Stages 6 and 7: blend along x, then along z
    logic signed [VW-1:0] r_r0;
    logic signed [VW-1:0] r_r1;
    logic signed [VW-1:0] r_ov;

    always_ff @(posedge i_clk) begin
        r_r0 <= fvnh_pkg::blend(r_s[0], r_s[1], r_fx[5]);
        r_r1 <= fvnh_pkg::blend(r_s[2], r_s[3], r_fx[5]);
        r_ov <= fvnh_pkg::blend(r_r0, r_r1, r_fz[6]);
    end

    // Stage 8: octave weighting and sum
    logic signed [AW-1:0] r_acc;
    logic                 r_acc_done;
    logic signed [AW-1:0] n_acc;

    always_comb begin
        n_acc = (r_toct[7] == '0) ? '0 : r_acc;
        n_acc = n_acc + AW'(r_ov >>> r_toct[7]);
    end

    always_ff @(posedge i_clk) begin
        if (r_vld[7]) r_acc <= n_acc;
    end

    // Stages 9 and 10: height scale, truncation toward zero, saturation
    logic signed [PRW-1:0] r_prod;
    logic                  r_prod_vld;
    logic [PRW-1:0]        mag;
    logic [PRW-31:0]       q;
    logic signed [PRW-30:0] h;
    logic signed [fvnh_pkg::OUT_W-1:0] n_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_done <= 1'b0;
            r_prod_vld <= 1'b0;
            o_done     <= 1'b0;
        end else begin
            r_acc_done <= r_vld[7] & r_last[7];
            r_prod_vld <= r_acc_done;
            o_done     <= r_prod_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod   <= PRW'(r_acc) * PRW'(signed'({1'b0, i_max_height}));
        o_height <= n_height;
    end

    always_comb begin
        mag = r_prod[PRW-1] ? PRW'(-r_prod) : PRW'(r_prod);
        q   = mag[PRW-1:30];
        h   = r_prod[PRW-1] ? -signed'({1'b0, q}) : signed'({1'b0, q});
        if (h > (PRW-29)'(OMAX)) begin
            n_height = OMAX;
        end else if (h < (PRW-29)'(OMIN)) begin
            n_height = OMIN;
        end else begin
            n_height = h[fvnh_pkg::OUT_W-1:0];
        end
    end

endmodule

`default_nettype wire

[design/fvnh_checker.sv]
// ----------------------------------------------------------------------------
// fvnh_checker
// Port-level checks of the request and result channels.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module fvnh_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic o_done,
    input wire logic pready
);

    // No two results are strobed in consecutive cycles.
    `FVNH_ASSERT_NEXT(a_done_spaced, o_done, !o_done)
    // The block can only fill up through a request taken the cycle before.
    `FVNH_ASSERT_IMP(a_busy_cause, $rose(busy), $past(start))
    // Reset leaves no result pending and the block ready.
    `FVNH_ASSERT_ALWAYS(a_reset_clear, !i_rst_n, !o_done && !busy)
    `FVNH_ASSERT_IMP(a_ready_high, 1'b1, pready)

endmodule

bind fractal_value_noise_height fvnh_checker u_fvnh_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .pready  (pready)
);

`default_nettype wire

[tb/tb_fractal_value_noise_height.sv]
// ----------------------------------------------------------------------------
// tb_fractal_value_noise_height
// Self-checking bench for the fractal value noise height block.
// ----------------------------------------------------------------------------
// Grid points are sent as requests in bursts with random gaps. Every accepted
// request is run through a local model of the six-octave noise sum, and the
// expected height is queued. Each strobed result is compared with the oldest
// entry. Both registers are rewritten between phases, extremes included.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_fractal_value_noise_height;

    localparam int NOCT      = fvnh_pkg::OCTAVES_DEF;
    localparam int GRID_W    = fvnh_pkg::COORD_BITS_DEF;
    localparam int IDLE_LIMIT = 5000;
    localparam int SETTLE    = 24;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic [GRID_W-1:0]       i_grid_x = '0;
    logic [GRID_W-1:0]       i_grid_z = '0;
    logic                    o_done;
    logic signed [fvnh_pkg::OUT_W-1:0] o_height;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [2:0]              paddr = '0;
    logic [31:0]             pwdata = '0;
    logic [31:0]             prdata;
    logic                    pready;

    fractal_value_noise_height dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_grid_x(i_grid_x), .i_grid_z(i_grid_z), .o_done(o_done),
        .o_height(o_height), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Register copies used by the height model.
    logic [fvnh_pkg::STEP_W-1:0]   step_q   = fvnh_pkg::STEP_RST;
    logic [fvnh_pkg::HEIGHT_W-1:0] height_q = fvnh_pkg::HEIGHT_RST;

    logic signed [fvnh_pkg::OUT_W-1:0] height_queue[$];
    int unsigned n_sent = 0;
    int unsigned n_checked = 0;
    int unsigned n_errors = 0;
    int unsigned idle_cycles = 0;
    int unsigned n_sat = 0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // ---------------- height model ----------------
    function automatic longint lattice_noise(input logic [31:0] ix, input logic [31:0] iz);
        logic [31:0] n;
        logic [31:0] t;
        n = ix + iz * fvnh_pkg::HASH_ROW;
        n = (n << 13) ^ n;
        t = (n * (n * n * fvnh_pkg::HASH_MUL + fvnh_pkg::HASH_ADD1) + fvnh_pkg::HASH_ADD2)
            & 32'h7fff_ffff;
        return 64'sd1073741824 - longint'({32'd0, t});
    endfunction

    function automatic longint smooth_noise(input logic [31:0] ix, input logic [31:0] iz);
        longint c;
        longint s;
        c = lattice_noise(ix - 1, iz - 1) + lattice_noise(ix + 1, iz - 1)
          + lattice_noise(ix - 1, iz + 1) + lattice_noise(ix + 1, iz + 1);
        s = lattice_noise(ix - 1, iz) + lattice_noise(ix + 1, iz)
          + lattice_noise(ix, iz - 1) + lattice_noise(ix, iz + 1);
        return (c + 2 * s + 4 * lattice_noise(ix, iz)) >>> 4;
    endfunction

    function automatic longint lerp_frac(input longint a, input longint b,
                                         input logic [15:0] f);
        return (a * (longint'(65536) - longint'(f)) + b * longint'(f)) >>> 16;
    endfunction

    function automatic longint octave_noise(input logic [63:0] px, input logic [63:0] pz);
        logic [31:0] ix;
        logic [31:0] iz;
        longint r0;
        longint r1;
        ix = px[47:16];
        iz = pz[47:16];
        r0 = lerp_frac(smooth_noise(ix, iz), smooth_noise(ix + 1, iz), px[15:0]);
        r1 = lerp_frac(smooth_noise(ix, iz + 1), smooth_noise(ix + 1, iz + 1), px[15:0]);
        return lerp_frac(r0, r1, pz[15:0]);
    endfunction

    function automatic logic signed [fvnh_pkg::OUT_W-1:0] terrain_height(
        input logic [GRID_W-1:0] gx,
        input logic [GRID_W-1:0] gz
    );
        logic [63:0] bx;
        logic [63:0] bz;
        longint sum;
        longint prod;
        longint h;
        bx = 64'(gx) * 64'(step_q);
        bz = 64'(gz) * 64'(step_q);
        sum = 0;
        for (int o = 0; o < NOCT; o++) begin
            sum += octave_noise(bx << o, bz << o) >>> o;
        end
        prod = sum * longint'({40'd0, height_q});
        if (prod < 0) begin
            h = -((-prod) >>> 30);
        end else begin
            h = prod >>> 30;
        end
        if (h > 64'sd33554431) h = 64'sd33554431;
        if (h < -64'sd33554432) h = -64'sd33554432;
        return h[fvnh_pkg::OUT_W-1:0];
    endfunction

    // ---------------- checking ----------------
    task automatic report_mismatch(input string what);
        n_errors++;
        $display("ERROR %s", what);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (height_queue.size() == 0) begin
                report_mismatch($sformatf("height %0d with no request pending", o_height));
            end else begin
                if (o_height !== height_queue[0]) begin
                    report_mismatch($sformatf("height got %0d expected %0d",
                                              o_height, height_queue[0]));
                end
                if (height_queue[0] == 26'sh1ffffff || height_queue[0] == -26'sh2000000)
                    n_sat++;
                void'(height_queue.pop_front());
                n_checked++;
            end
        end
    end

    // Ends the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout with %0d heights outstanding", height_queue.size());
                $display("tb_fractal_value_noise_height NOT OK");
                $finish;
            end
        end
    end

    // ---------------- stimulus helpers ----------------
    // Called just after a rising edge; start is left high for the caller.
    task automatic send_point(input logic [GRID_W-1:0] gx, input logic [GRID_W-1:0] gz);
        i_grid_x <= gx;
        i_grid_z <= gz;
        start    <= 1'b1;
        do @(posedge i_clk); while (busy);
        height_queue.insert(height_queue.size(), terrain_height(gx, gz));
        n_sent++;
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0) begin
            start <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    task automatic drain_heights();
        start <= 1'b0;
        while (height_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input fvnh_pkg::t_reg idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // An idle state between accesses keeps back-to-back writes apart.
        @(posedge i_clk);
        if (idx == fvnh_pkg::REG_COORD_STEP) step_q = value[fvnh_pkg::STEP_W-1:0];
        else height_q = value[fvnh_pkg::HEIGHT_W-1:0];
    endtask

    task automatic set_config(input logic [31:0] stepv, input logic [31:0] hv);
        drain_heights();
        write_reg(fvnh_pkg::REG_COORD_STEP, stepv);
        write_reg(fvnh_pkg::REG_MAX_HEIGHT, hv);
    endtask

    // Random points in bursts; a quarter are small, a quarter sit at the upper x edge, the rest are random.
    task automatic random_burst_run(input int count);
        int burst;
        logic [GRID_W-1:0] gx;
        logic [GRID_W-1:0] gz;
        burst = $urandom_range(1, 16);
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(0, 3))
                0: begin
                    gx = GRID_W'($urandom_range(0, 63));
                    gz = GRID_W'($urandom_range(0, 63));
                end
                1: begin
                    gx = GRID_W'(4095 - $urandom_range(0, 3));
                    gz = GRID_W'($urandom);
                end
                default: begin
                    gx = GRID_W'($urandom);
                    gz = GRID_W'($urandom);
                end
            endcase
            send_point(gx, gz);
            if (--burst == 0) begin
                burst = $urandom_range(1, 16);
                if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 12));
            end
        end
    endtask

    // ---------------- tests ----------------
    task automatic test_reset_values();
        send_point(0, 0);
        send_point(4095, 4095);
        send_point(4095, 0);
        send_point(0, 4095);
        send_point(12'haaa, 12'h555);
        send_point(12'h555, 12'haaa);
        send_point(1, 1);
    endtask

    task automatic test_zero_step();
        set_config(0, 256);
        send_point(0, 0);
        send_point(4095, 4095);
        send_point(12'h123, 12'h800);
    endtask

    task automatic test_register_extremes();
        set_config(32'hffff_ffff, 32'hffff_ffff);
        send_point(4095, 4095);
        send_point(4095, 1);
        send_point(1, 0);
        send_point(2048, 2047);
        set_config(32'h0000_0001, 0);
        send_point(4095, 4095);
        send_point(17, 3);
        set_config(20'h80000, 24'h800000);
        send_point(4095, 0);
        send_point(0, 4095);
        send_point(3000, 1000);
    endtask

    task automatic test_random_configs();
        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: set_config(65536 * 8 / (1 << $urandom_range(3, 12)), $urandom_range(0, 65535));
                1: set_config($urandom, $urandom);
                2: set_config($urandom_range(0, 2048), 24'hffffff);
                default: set_config($urandom_range(0, 20'hfffff), $urandom_range(0, 4096));
            endcase
            random_burst_run(100);
            // Hold the sender off until every height of the burst is back.
            if (phase == 3) drain_heights();
        end
    endtask

    task automatic test_back_to_back();
        set_config(20'h02000, 24'h010000);
        for (int k = 0; k < 30; k++) send_point(GRID_W'($urandom), GRID_W'($urandom));
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_values();
        test_zero_step();
        test_register_extremes();
        test_back_to_back();
        test_random_configs();
        drain_heights();
        $display("Sent %0d points, checked %0d heights, %0d at saturation.",
                 n_sent, n_checked, n_sat);
        $display("Covered reset values, zero and full-scale step and height, random configs.");
        if (n_errors == 0) begin
            $display("tb_fractal_value_noise_height OK");
        end else begin
            $display("tb_fractal_value_noise_height NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire
